FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MRLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mrle assertion failed");

// Checked at every edge, reset included.
`define MRLE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mrle assertion failed");

`endif

FILE: src/mrle_pkg.sv
// Shared types, codes and helpers of the mask RLE stream decoder.
package mrle_pkg;

  localparam logic [2:0] KIND_HDR  = 3'd0;
  localparam logic [2:0] KIND_MASK = 3'd1;
  localparam logic [2:0] KIND_RUN  = 3'd2;
  localparam logic [2:0] KIND_VAL  = 3'd3;
  localparam logic [2:0] KIND_ERR  = 3'd4;

  localparam int HDR_LEN    = 8;   // header bytes held before the last one arrives
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam logic [7:0] RUN_FLAG = 8'h80;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_HDR  = 5'b00010,
    PH_MASK = 5'b00100,
    PH_VAL  = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        frame_index;
    logic [14:0]        mask;
    logic [15:0]        start_index;
    logic [6:0]         run_length;
    logic [7:0]         byte_value;
    logic [31:0]        value_index;
    logic signed [7:0]  first_frame;
    logic [15:0]        frame_count;
    logic [7:0]         frame_rate;
    logic [7:0]         target_count;
    logic [31:0]        value_count;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [3:0] popcount15(input logic [14:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 15; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

FILE: src/mrle_in_if.sv
// Input byte channel.
interface mrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       blob_start;

  modport source (output valid, output byte_in, output blob_start, input ready);
  modport sink   (input valid, input byte_in, input blob_start, output ready);
endinterface

FILE: src/mrle_out_if.sv
// Result record channel.
interface mrle_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [15:0]        frame_index;
  logic [14:0]        mask;
  logic [15:0]        start_index;
  logic [6:0]         run_length;
  logic [7:0]         byte_value;
  logic [31:0]        value_index;
  logic signed [7:0]  first_frame;
  logic [15:0]        frame_count;
  logic [7:0]         frame_rate;
  logic [7:0]         target_count;
  logic [31:0]        value_count;

  modport source (output valid, output kind, output frame_index, output mask,
                  output start_index, output run_length, output byte_value,
                  output value_index, output first_frame, output frame_count,
                  output frame_rate, output target_count, output value_count,
                  input ready);
  modport sink   (input valid, input kind, input frame_index, input mask,
                  input start_index, input run_length, input byte_value,
                  input value_index, input first_frame, input frame_count,
                  input frame_rate, input target_count, input value_count,
                  output ready);
endinterface

FILE: src/mrle_queue.sv
// Short record queue between the parser and the output stage.
module mrle_queue
  import mrle_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  res_t   push_data,
  input  logic   pop,
  output res_t   pop_data,
  output qstat_t stat
);

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: src/mrle_front.sv
// Byte parser: header capture, mask/run/value classification, frame and value counts.
module mrle_front
  import mrle_pkg::*;
#(
  parameter int MASK_WIDTH = 15
) (
  input  logic   clk,
  input  logic   rst_n,
  mrle_in_if.sink in_ch,
  input  qstat_t q_stat,
  output logic   push,
  output res_t   push_data
);

  localparam logic [14:0] MASK_KEEP = 15'((32'd1 << MASK_WIDTH) - 32'd1);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hdr_pos_r, hdr_pos_nxt;
  logic [7:0]  hdr_r [HDR_LEN];
  logic [15:0] tot_frames_r, tot_frames_nxt;
  logic [31:0] tot_values_r, tot_values_nxt;
  logic [15:0] frames_done_r, frames_done_nxt;
  logic        high_pend_r, high_pend_nxt;
  logic [6:0]  high_bits_r, high_bits_nxt;
  logic [31:0] values_done_r, values_done_nxt;

  logic        accept;
  logic        hdr_wr;
  logic [2:0]  hdr_wr_idx;
  logic [7:0]  b;
  logic [15:0] left;
  logic [16:0] frames_sum;
  logic [15:0] fc;
  logic [31:0] vc;
  logic [6:0]  run_n;
  res_t        res;
  logic        has_res;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_in;
  assign left        = tot_frames_r - frames_done_r;
  assign fc          = {hdr_r[2], hdr_r[1]};
  assign vc          = {b, hdr_r[7], hdr_r[6], hdr_r[5]};
  assign push        = accept && has_res;
  assign push_data   = res;

  always_comb begin
    phase_nxt       = phase_r;
    hdr_pos_nxt     = hdr_pos_r;
    tot_frames_nxt  = tot_frames_r;
    tot_values_nxt  = tot_values_r;
    frames_done_nxt = frames_done_r;
    high_pend_nxt   = high_pend_r;
    high_bits_nxt   = high_bits_r;
    values_done_nxt = values_done_r;
    hdr_wr          = 1'b0;
    hdr_wr_idx      = hdr_pos_r[2:0];
    frames_sum      = 17'(frames_done_r);
    run_n           = b[6:0];
    res             = '0;
    has_res         = 1'b0;

    if (accept) begin
      if (in_ch.blob_start) begin
        // restart: this byte is header byte 0
        phase_nxt       = PH_HDR;
        hdr_pos_nxt     = 4'd1;
        hdr_wr          = 1'b1;
        hdr_wr_idx      = '0;
        tot_frames_nxt  = '0;
        tot_values_nxt  = '0;
        frames_done_nxt = '0;
        high_pend_nxt   = 1'b0;
        high_bits_nxt   = '0;
        values_done_nxt = '0;
      end else begin
        case (phase_r)
          PH_HDR: begin
            if (hdr_pos_r < 4'(HDR_LEN)) begin
              hdr_wr      = 1'b1;
              hdr_pos_nxt = hdr_pos_r + 4'd1;
            end else begin
              has_res          = 1'b1;
              res.kind         = KIND_HDR;
              res.first_frame  = hdr_r[0];
              res.frame_count  = fc;
              res.frame_rate   = hdr_r[3];
              res.target_count = hdr_r[4];
              res.value_count  = vc;
              tot_frames_nxt   = fc;
              tot_values_nxt   = vc;
              hdr_pos_nxt      = '0;
              if (fc != '0) begin
                phase_nxt = PH_MASK;
              end else begin
                phase_nxt = (vc == '0) ? PH_DONE : PH_VAL;
              end
            end
          end
          PH_MASK: begin
            if (high_pend_r) begin
              has_res         = 1'b1;
              res.kind        = KIND_MASK;
              res.frame_index = frames_done_r;
              res.mask        = {high_bits_r, b} & MASK_KEEP;
              high_pend_nxt   = 1'b0;
              frames_sum      = 17'(frames_done_r) + 17'd1;
            end else if ((b & RUN_FLAG) != '0) begin
              if (run_n != '0) begin
                has_res         = 1'b1;
                res.frame_index = frames_done_r;
                if (16'(run_n) > left) begin
                  res.kind = KIND_ERR;
                  run_n    = left[6:0];
                end else begin
                  res.kind = KIND_RUN;
                end
                res.run_length = run_n;
                frames_sum     = 17'(frames_done_r) + 17'(run_n);
              end
            end else begin
              high_bits_nxt = b[6:0];
              high_pend_nxt = 1'b1;
            end
            frames_done_nxt = frames_sum[15:0];
            if (has_res && frames_sum >= 17'(tot_frames_r)) begin
              phase_nxt = (tot_values_r == '0) ? PH_DONE : PH_VAL;
            end
          end
          PH_VAL: begin
            has_res         = 1'b1;
            res.kind        = KIND_VAL;
            res.byte_value  = b;
            res.value_index = values_done_r;
            values_done_nxt = values_done_r + 32'd1;
            if (values_done_nxt >= tot_values_r) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_IDLE, PH_DONE: begin
            // drop the byte
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_r[hdr_wr_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      hdr_pos_r     <= '0;
      tot_frames_r  <= '0;
      tot_values_r  <= '0;
      frames_done_r <= '0;
      high_pend_r   <= 1'b0;
      high_bits_r   <= '0;
      values_done_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      hdr_pos_r     <= hdr_pos_nxt;
      tot_frames_r  <= tot_frames_nxt;
      tot_values_r  <= tot_values_nxt;
      frames_done_r <= frames_done_nxt;
      high_pend_r   <= high_pend_nxt;
      high_bits_r   <= high_bits_nxt;
      values_done_r <= values_done_nxt;
    end
  end

endmodule

FILE: src/mrle_back.sv
// Output stage: popcount prefix for frame masks and the result register.
module mrle_back
  import mrle_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  qstat_t q_stat,
  input  res_t   q_data,
  output logic   pop,
  mrle_out_if.source out_ch
);

  logic        out_valid_r;
  res_t        out_r;
  res_t        out_nxt;
  logic [15:0] running_r, running_nxt;

  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_nxt     = q_data;
    running_nxt = running_r;
    case (q_data.kind)
      KIND_HDR: begin
        running_nxt = '0;
      end
      KIND_MASK: begin
        out_nxt.start_index = running_r;
        running_nxt         = running_r + 16'(popcount15(q_data.mask));
      end
      default: begin
        running_nxt = running_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      running_r   <= '0;
    end else begin
      if (pop) begin
        out_valid_r <= 1'b1;
        running_r   <= running_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.frame_index  = out_r.frame_index;
  assign out_ch.mask         = out_r.mask;
  assign out_ch.start_index  = out_r.start_index;
  assign out_ch.run_length   = out_r.run_length;
  assign out_ch.byte_value   = out_r.byte_value;
  assign out_ch.value_index  = out_r.value_index;
  assign out_ch.first_frame  = out_r.first_frame;
  assign out_ch.frame_count  = out_r.frame_count;
  assign out_ch.frame_rate   = out_r.frame_rate;
  assign out_ch.target_count = out_r.target_count;
  assign out_ch.value_count  = out_r.value_count;

endmodule

FILE: src/mask_rle_stream_decoder.sv
// Top level of the mask RLE stream decoder.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   in_ch    | sink      | byte_in, blob_start
//   out_ch   | source    | kind, frame/mask/run/value fields, header fields
//
// One byte is accepted per cycle while the queue is not full; a byte that yields a record is
// written into the queue, and from there into the output register that drives out_ch.
// The parser updates its state on every accepted byte; the two-entry queue holds records while
// out_ch stalls, and in_ch.ready drops once the queue is full.
// rst_n is synchronous; it returns the parser to idle and empties queue and output.
module mask_rle_stream_decoder
  import mrle_pkg::*;
#(
  parameter int MASK_WIDTH = 15
) (
  input  logic clk,
  input  logic rst_n,
  mrle_in_if.sink    in_ch,
  mrle_out_if.source out_ch
);

  logic   push;
  logic   pop;
  res_t   push_data;
  res_t   q_data;
  qstat_t q_stat;

  mrle_front #(.MASK_WIDTH(MASK_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mrle_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .stat      (q_stat)
  );

  mrle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (q_data),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: src/mrle_checker.sv
// Port-level checker for the decoder, bound to the top level.
`include "assert_macros.svh"

module mrle_checker
  import mrle_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [14:0] mask,
  input logic [15:0] start_index,
  input logic [6:0]  run_length,
  input logic [7:0]  byte_value,
  input logic [31:0] value_index
);

  `MRLE_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(start_index))
  `MRLE_ASSERT(a_kind, clk, rst_n, out_valid |-> (kind == KIND_HDR || kind == KIND_MASK || kind == KIND_RUN || kind == KIND_VAL || kind == KIND_ERR))
  `MRLE_ASSERT(a_mask_clean, clk, rst_n, out_valid && kind == KIND_MASK |-> run_length == '0 && byte_value == '0 && value_index == '0)
  `MRLE_ASSERT(a_run_clean, clk, rst_n, out_valid && (kind == KIND_RUN || kind == KIND_ERR) |-> mask == '0 && start_index == '0 && run_length != '0)
  `MRLE_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_valid)

endmodule

bind mask_rle_stream_decoder mrle_checker u_mrle_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .mask        (out_ch.mask),
  .start_index (out_ch.start_index),
  .run_length  (out_ch.run_length),
  .byte_value  (out_ch.byte_value),
  .value_index (out_ch.value_index)
);
